>>> rtl/core/glos_pkg.sv
`timescale 1ns / 1ps

package glos_pkg;

  // Fixed field and map geometry
  localparam int ID_W      = 12;
  localparam int MAP_DEPTH = 4096;
  localparam int DIM_W     = 7;
  localparam int CELLS_W   = 2 * DIM_W;

  // Tile id split: one quotient bit per step
  localparam int DIV_CNT_W = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ID_W - 1);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic            func;
    logic [ID_W-1:0] start_tile;
    logic [ID_W-1:0] end_tile;
    logic            passable;
  } glos_req_t;

  typedef struct packed {
    logic clear_path;
    logic bad_id;
  } glos_rsp_t;

  // Microprogram step addresses
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_CLR     = 5'd0;
  localparam step_t ST_IDLE    = 5'd1;
  localparam step_t ST_DISP    = 5'd2;
  localparam step_t ST_CHKBAD  = 5'd3;
  localparam step_t ST_CHKSAME = 5'd4;
  localparam step_t ST_DIVS    = 5'd5;
  localparam step_t ST_DIVSL   = 5'd6;
  localparam step_t ST_SAVES   = 5'd7;
  localparam step_t ST_DIVE    = 5'd8;
  localparam step_t ST_DIVEL   = 5'd9;
  localparam step_t ST_SAVEE   = 5'd10;
  localparam step_t ST_ORIENT  = 5'd11;
  localparam step_t ST_LOAD    = 5'd12;
  localparam step_t ST_CHKD    = 5'd13;
  localparam step_t ST_ADJ     = 5'd14;
  localparam step_t ST_RDA     = 5'd15;
  localparam step_t ST_RDB     = 5'd16;
  localparam step_t ST_CHKB    = 5'd17;
  localparam step_t ST_NEXT    = 5'd18;
  localparam step_t ST_PASS    = 5'd19;
  localparam step_t ST_FAIL    = 5'd20;
  localparam step_t ST_BAD     = 5'd21;
  localparam step_t ST_EMIT    = 5'd22;
  localparam step_t ST_RET     = 5'd23;
  localparam step_t ST_WR      = 5'd24;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLR,
    OP_TAKE,
    OP_DIV_LOAD_S,
    OP_DIV_LOAD_E,
    OP_DIV_STEP,
    OP_SAVE_S,
    OP_SAVE_E,
    OP_ORIENT,
    OP_LOAD_LINE,
    OP_ADJ,
    OP_RD_FAR,
    OP_RD_NEAR,
    OP_ADVANCE,
    OP_SET_PASS,
    OP_SET_FAIL,
    OP_SET_BAD,
    OP_EMIT,
    OP_WRITE
  } glos_op_t;

  typedef enum logic [3:0] {
    CD_NEVER,
    CD_ALWAYS,
    CD_CLR_MORE,
    CD_NO_REQ,
    CD_WRITE,
    CD_BAD,
    CD_SAME,
    CD_DIV_MORE,
    CD_NO_BND,
    CD_ADJ_MORE,
    CD_BLOCKED,
    CD_BLOCKED_ND,
    CD_BND_MORE,
    CD_OUT_BUSY
  } glos_cd_t;

  typedef struct packed {
    logic clr_more;
    logic no_req;
    logic write;
    logic bad;
    logic same;
    logic div_more;
    logic no_bnd;
    logic adj_more;
    logic blocked;
    logic blocked_nd;
    logic bnd_more;
    logic out_busy;
  } glos_flags_t;

  typedef struct packed {
    glos_op_t op;
    glos_cd_t cd;
    step_t    target;
  } glos_ctl_t;

  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] waddr;
    logic            wdata;
    logic [ID_W-1:0] raddr;
  } glos_map_req_t;

  // Control store: jump to target when the condition holds, else fall through
  function automatic glos_ctl_t glos_rom(input step_t step);
    glos_ctl_t w;
    case (step)
      ST_CLR:     w = '{OP_CLR,        CD_CLR_MORE,   ST_CLR};
      ST_IDLE:    w = '{OP_TAKE,       CD_NO_REQ,     ST_IDLE};
      ST_DISP:    w = '{OP_NOP,        CD_WRITE,      ST_WR};
      ST_CHKBAD:  w = '{OP_NOP,        CD_BAD,        ST_BAD};
      ST_CHKSAME: w = '{OP_NOP,        CD_SAME,       ST_PASS};
      ST_DIVS:    w = '{OP_DIV_LOAD_S, CD_NEVER,      ST_IDLE};
      ST_DIVSL:   w = '{OP_DIV_STEP,   CD_DIV_MORE,   ST_DIVSL};
      ST_SAVES:   w = '{OP_SAVE_S,     CD_NEVER,      ST_IDLE};
      ST_DIVE:    w = '{OP_DIV_LOAD_E, CD_NEVER,      ST_IDLE};
      ST_DIVEL:   w = '{OP_DIV_STEP,   CD_DIV_MORE,   ST_DIVEL};
      ST_SAVEE:   w = '{OP_SAVE_E,     CD_NEVER,      ST_IDLE};
      ST_ORIENT:  w = '{OP_ORIENT,     CD_NEVER,      ST_IDLE};
      ST_LOAD:    w = '{OP_LOAD_LINE,  CD_NEVER,      ST_IDLE};
      ST_CHKD:    w = '{OP_NOP,        CD_NO_BND,     ST_PASS};
      ST_ADJ:     w = '{OP_ADJ,        CD_ADJ_MORE,   ST_ADJ};
      ST_RDA:     w = '{OP_RD_FAR,     CD_NEVER,      ST_IDLE};
      ST_RDB:     w = '{OP_RD_NEAR,    CD_BLOCKED,    ST_FAIL};
      ST_CHKB:    w = '{OP_NOP,        CD_BLOCKED_ND, ST_FAIL};
      ST_NEXT:    w = '{OP_ADVANCE,    CD_BND_MORE,   ST_ADJ};
      ST_PASS:    w = '{OP_SET_PASS,   CD_ALWAYS,     ST_EMIT};
      ST_FAIL:    w = '{OP_SET_FAIL,   CD_ALWAYS,     ST_EMIT};
      ST_BAD:     w = '{OP_SET_BAD,    CD_NEVER,      ST_IDLE};
      ST_EMIT:    w = '{OP_EMIT,       CD_OUT_BUSY,   ST_EMIT};
      ST_RET:     w = '{OP_NOP,        CD_ALWAYS,     ST_IDLE};
      ST_WR:      w = '{OP_WRITE,      CD_ALWAYS,     ST_IDLE};
      default:    w = '{OP_NOP,        CD_ALWAYS,     ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/glos_ram.sv
`timescale 1ns / 1ps

module glos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/glos_seq.sv
`timescale 1ns / 1ps

module glos_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  glos_pkg::glos_flags_t flags,
  output glos_pkg::glos_ctl_t   ctl
);

  glos_pkg::step_t upc;
  glos_pkg::step_t upc_next;
  logic            jump;

  assign ctl = glos_pkg::glos_rom(upc);

  always_comb begin
    case (ctl.cd)
      glos_pkg::CD_NEVER:      jump = 1'b0;
      glos_pkg::CD_ALWAYS:     jump = 1'b1;
      glos_pkg::CD_CLR_MORE:   jump = flags.clr_more;
      glos_pkg::CD_NO_REQ:     jump = flags.no_req;
      glos_pkg::CD_WRITE:      jump = flags.write;
      glos_pkg::CD_BAD:        jump = flags.bad;
      glos_pkg::CD_SAME:       jump = flags.same;
      glos_pkg::CD_DIV_MORE:   jump = flags.div_more;
      glos_pkg::CD_NO_BND:     jump = flags.no_bnd;
      glos_pkg::CD_ADJ_MORE:   jump = flags.adj_more;
      glos_pkg::CD_BLOCKED:    jump = flags.blocked;
      glos_pkg::CD_BLOCKED_ND: jump = flags.blocked_nd;
      glos_pkg::CD_BND_MORE:   jump = flags.bnd_more;
      glos_pkg::CD_OUT_BUSY:   jump = flags.out_busy;
      default:                 jump = 1'b0;
    endcase
    upc_next = jump ? ctl.target : glos_pkg::step_t'(upc + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= glos_pkg::ST_CLR;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

>>> rtl/core/glos_dp.sv
`timescale 1ns / 1ps

module glos_dp #(
  parameter int CW = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  glos_pkg::glos_ctl_t           ctl,
  input  logic [glos_pkg::DIM_W-1:0]    cols,
  input  logic [glos_pkg::DIM_W-1:0]    rows,
  input  glos_pkg::glos_req_t           req,
  input  logic                          req_valid,
  input  logic                          rsp_stall,
  output glos_pkg::glos_rsp_t           rsp,
  output logic                          rsp_valid,
  output glos_pkg::glos_flags_t         flags,
  output glos_pkg::glos_map_req_t       map_req,
  input  logic                          map_rdata
);

  localparam int DIM_W = glos_pkg::DIM_W;
  localparam int ID_W  = glos_pkg::ID_W;
  localparam int QW    = CW + 1;   // doubled minor coordinate
  localparam int DNW   = CW + 2;   // doubled minor delta, signed
  localparam int RW    = CW + 4;   // DDA remainder, signed
  localparam int AW    = (CW + DIM_W + 1 > ID_W) ? CW + DIM_W + 1 : ID_W;

  logic [glos_pkg::CELLS_W-1:0]   cells;
  logic [ID_W-1:0]                clr_cnt;
  logic [ID_W-1:0]                st;
  logic [ID_W-1:0]                en;
  logic                           pv;
  logic                           is_write;
  logic                           bad;
  logic                           same;

  // shift-subtract divider for the tile id split
  logic [ID_W-1:0]                dq;
  logic [DIM_W-1:0]               drem;
  logic [glos_pkg::DIV_CNT_W-1:0] dcnt;
  logic [DIM_W:0]                 dsh;
  logic [DIM_W:0]                 dtrial;
  logic                           dfit;

  logic [CW-1:0]                  sx, sy, ex, ey;
  logic [CW-1:0]                  adx, ady;
  logic                           along, diag;
  logic [CW-1:0]                  ma, mb, na, nb;
  logic                           swap;
  logic [CW-1:0]                  ml_new, dt_new, nlo, nhi;
  logic [DNW-1:0]                 dn_u;
  logic signed [DNW-1:0]          dn_new;

  logic [CW-1:0]                  ml;
  logic [CW-1:0]                  dt;
  logic [CW-1:0]                  k;
  logic signed [DNW-1:0]          dn;
  logic [QW-1:0]                  q;
  logic signed [RW-1:0]           r;
  logic signed [RW-1:0]           dm_s;
  logic signed [RW-1:0]           dn2_s;
  logic                           r_neg, r_big;

  logic [CW:0]                    maj_sum;
  logic [CW-1:0]                  maj, minr, tx, ty;
  logic [AW-1:0]                  addr_full;

  logic                           clear_r;
  logic                           bad_r;
  logic                           out_busy;

  assign cells = glos_pkg::CELLS_W'(cols) * glos_pkg::CELLS_W'(rows);

  assign dsh    = {drem, dq[ID_W-1]};
  assign dfit   = dsh >= {1'b0, cols};
  assign dtrial = dsh - {1'b0, cols};

  assign adx = (sx > ex) ? sx - ex : ex - sx;
  assign ady = (sy > ey) ? sy - ey : ey - sy;

  // order endpoints so the major coordinate rises
  always_comb begin
    ma     = along ? sx : sy;
    mb     = along ? ex : ey;
    na     = along ? sy : sx;
    nb     = along ? ey : ex;
    swap   = ma > mb;
    ml_new = swap ? mb : ma;
    dt_new = swap ? ma - mb : mb - ma;
    nlo    = swap ? nb : na;
    nhi    = swap ? na : nb;
    dn_u   = {1'b0, nhi, 1'b0} - {1'b0, nlo, 1'b0};
    dn_new = signed'(dn_u);
  end

  assign dm_s  = signed'({{(RW-CW-1){1'b0}}, dt, 1'b0});
  assign dn2_s = signed'({{(RW-DNW-1){dn[DNW-1]}}, dn, 1'b0});
  assign r_neg = r[RW-1];
  assign r_big = !r_neg && (r >= dm_s);

  // tile beside the current boundary: far side, or near side one back
  always_comb begin
    maj_sum   = {1'b0, ml} + {1'b0, k} - (CW + 1)'(ctl.op == glos_pkg::OP_RD_NEAR);
    maj       = maj_sum[CW-1:0];
    minr      = q[QW-1:1];
    tx        = along ? maj : minr;
    ty        = along ? minr : maj;
    addr_full = AW'(ty) * AW'(cols) + AW'(tx);
  end

  assign out_busy = rsp_valid && rsp_stall;

  always_comb begin
    flags.clr_more   = clr_cnt != ID_W'(glos_pkg::MAP_DEPTH - 1);
    flags.no_req     = !req_valid;
    flags.write      = is_write;
    flags.bad        = bad;
    flags.same       = same;
    flags.div_more   = dcnt != glos_pkg::DIV_LAST;
    flags.no_bnd     = dt == '0;
    flags.adj_more   = r_neg || r_big;
    flags.blocked    = !map_rdata;
    flags.blocked_nd = !map_rdata && !diag;
    flags.bnd_more   = k != dt;
    flags.out_busy   = out_busy;
  end

  always_comb begin
    map_req.we    = (ctl.op == glos_pkg::OP_CLR) || (ctl.op == glos_pkg::OP_WRITE);
    map_req.waddr = (ctl.op == glos_pkg::OP_CLR) ? clr_cnt : st;
    map_req.wdata = (ctl.op == glos_pkg::OP_WRITE) ? pv : 1'b0;
    map_req.raddr = addr_full[ID_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.op == glos_pkg::OP_CLR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      glos_pkg::OP_TAKE: begin
        if (req_valid) begin
          st       <= req.start_tile;
          en       <= req.end_tile;
          pv       <= req.passable;
          is_write <= req.func == glos_pkg::FUNC_WRITE;
          bad      <= (glos_pkg::CELLS_W'(req.start_tile) >= cells) ||
                      (glos_pkg::CELLS_W'(req.end_tile) >= cells);
          same     <= req.start_tile == req.end_tile;
        end
      end
      glos_pkg::OP_DIV_LOAD_S: begin
        dq   <= st;
        drem <= '0;
        dcnt <= '0;
      end
      glos_pkg::OP_DIV_LOAD_E: begin
        dq   <= en;
        drem <= '0;
        dcnt <= '0;
      end
      glos_pkg::OP_DIV_STEP: begin
        drem <= dfit ? dtrial[DIM_W-1:0] : dsh[DIM_W-1:0];
        dq   <= {dq[ID_W-2:0], dfit};
        dcnt <= dcnt + 1'b1;
      end
      glos_pkg::OP_SAVE_S: begin
        sx <= drem[CW-1:0];
        sy <= dq[CW-1:0];
      end
      glos_pkg::OP_SAVE_E: begin
        ex <= drem[CW-1:0];
        ey <= dq[CW-1:0];
      end
      glos_pkg::OP_ORIENT: begin
        along <= adx >= ady;
        diag  <= adx == ady;
      end
      glos_pkg::OP_LOAD_LINE: begin
        ml <= ml_new;
        dt <= dt_new;
        k  <= CW'(1);
        dn <= dn_new;
        q  <= {nlo, 1'b1};
        r  <= signed'({{(RW-DNW){dn_new[DNW-1]}}, dn_new});
      end
      glos_pkg::OP_ADJ: begin
        if (r_neg) begin
          r <= r + dm_s;
          q <= q - 1'b1;
        end else if (r_big) begin
          r <= r - dm_s;
          q <= q + 1'b1;
        end
      end
      glos_pkg::OP_ADVANCE: begin
        r <= r + dn2_s;
        k <= k + 1'b1;
      end
      glos_pkg::OP_SET_PASS: begin
        clear_r <= 1'b1;
        bad_r   <= 1'b0;
      end
      glos_pkg::OP_SET_FAIL: begin
        clear_r <= 1'b0;
        bad_r   <= 1'b0;
      end
      glos_pkg::OP_SET_BAD: begin
        clear_r <= 1'b0;
        bad_r   <= 1'b1;
      end
      glos_pkg::OP_EMIT: begin
        if (!out_busy) begin
          rsp.clear_path <= clear_r;
          rsp.bad_id     <= bad_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.op == glos_pkg::OP_EMIT && !out_busy) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/grid_line_of_sight_check.sv
`timescale 1ns / 1ps

// channel   dir  signals                                   transfer
// --------  ---  ----------------------------------------  --------------------------------
// request   in   req_valid, req_stall, req                  req_valid && !req_stall
// response  out  rsp_valid, rsp_stall, rsp                  rsp_valid && !rsp_stall
// config    in   psel, penable, pwrite, paddr, pwdata,      psel && penable && pwrite
//                prdata, pready                             (pready tied high)
//
// Map write: the request is taken at idle, dispatched, and written to the map.
// Query: the tile ids are split into x and y, the line is set up, then the boundary
//   loop in the microprogram (remainder fixup, two map reads, advance) runs for each
//   grid boundary crossed. Out-of-grid and equal-tile queries skip the split and loop.
// After reset the map is swept to blocked, one entry a cycle; no request is taken
//   during the sweep, config writes are.
// A held response only stalls the sequencer at its emit step; the next request
//   is taken while the response waits.

module grid_line_of_sight_check #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                req_valid,
  output logic                req_stall,
  input  glos_pkg::glos_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output glos_pkg::glos_rsp_t rsp
);

  localparam int DIM_W   = glos_pkg::DIM_W;
  localparam int DIM_MAX = (1 << DIM_W) - 1;

  // dimension registers are 7 bits, so the usable cap is the smaller of the two
  localparam int COL_CAP = (MAX_COLUMNS > DIM_MAX) ? DIM_MAX : MAX_COLUMNS;
  localparam int ROW_CAP = (MAX_ROWS > DIM_MAX) ? DIM_MAX : MAX_ROWS;
  localparam int XW      = $clog2(COL_CAP);
  localparam int YW      = $clog2(ROW_CAP);
  // coordinate width, wide enough for either axis to be the major one
  localparam int CW      = (XW > YW) ? XW : YW;

  localparam logic [DIM_W-1:0] COL_CAP_V = DIM_W'(COL_CAP);
  localparam logic [DIM_W-1:0] ROW_CAP_V = DIM_W'(ROW_CAP);
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

  // register index, taken from the address word bit
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  logic [DIM_W-1:0]               grid_columns;
  logic [DIM_W-1:0]               grid_rows;
  logic [DIM_W-1:0]               cols;
  logic [DIM_W-1:0]               rows;
  logic                           cfg_wr;

  glos_pkg::glos_ctl_t            ctl;
  glos_pkg::glos_flags_t          flags;
  glos_pkg::glos_map_req_t        map_req;
  logic [0:0]                     map_rdata;

  // ---------------- config port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= DIM_RESET;
      grid_rows    <= DIM_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_COLUMNS: grid_columns <= pwdata[DIM_W-1:0];
        REG_ROWS:    grid_rows    <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign prdata = {{(32-DIM_W){1'b0}}, (paddr[2] == REG_ROWS) ? grid_rows : grid_columns};

  // zero is used as one, anything above the cap as the cap (prdata shows the raw value)
  assign cols = (grid_columns == '0) ? DIM_W'(1) :
                (grid_columns > COL_CAP_V) ? COL_CAP_V : grid_columns;
  assign rows = (grid_rows == '0) ? DIM_W'(1) :
                (grid_rows > ROW_CAP_V) ? ROW_CAP_V : grid_rows;

  // ---------------- request side ----------------
  // only the idle step of the microprogram takes a request
  assign req_stall = ctl.op != glos_pkg::OP_TAKE;

  glos_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  glos_dp #(
    .CW (CW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cols      (cols),
    .rows      (rows),
    .req       (req),
    .req_valid (req_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .flags     (flags),
    .map_req   (map_req),
    .map_rdata (map_rdata[0])
  );

  // passability map: one bit per tile id, registered read
  glos_ram #(
    .WIDTH (1),
    .DEPTH (glos_pkg::MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_req.we),
    .waddr (map_req.waddr),
    .wdata (map_req.wdata),
    .raddr (map_req.raddr),
    .rdata (map_rdata)
  );

endmodule
